// ===== src/als_pkg.sv =====
// types, constants and cost arithmetic shared by the assembly line scheduler
package als_pkg;

  localparam int COST_W     = 16;
  localparam int TOTAL_W    = 24;
  localparam int STATION_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_LINE1 = 2'd0,
    CFG_ENTRY_LINE2 = 2'd1,
    CFG_EXIT_LINE1  = 2'd2,
    CFG_EXIT_LINE2  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } als_state_t;

  localparam logic KIND_STATION = 1'b0;
  localparam logic KIND_FINISH  = 1'b1;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

// ===== src/als_in_if.sv =====
// station and finish word channel
interface als_in_if import als_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [COST_W-1:0] cost_line1;
  logic [COST_W-1:0] cost_line2;
  logic [COST_W-1:0] xfer_to_line1;
  logic [COST_W-1:0] xfer_to_line2;

  modport source (output valid, kind, cost_line1, cost_line2, xfer_to_line1,
                  xfer_to_line2, input ready);
  modport sink   (input valid, kind, cost_line1, cost_line2, xfer_to_line1,
                  xfer_to_line2, output ready);
endinterface

// ===== src/als_out_if.sv =====
// schedule result word channel
interface als_out_if import als_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATION_W-1:0] station_index;
  logic                 line;
  logic [TOTAL_W-1:0]   total_cost;
  logic                 last;
  logic                 no_stations;
  logic                 overflow;

  modport source (output valid, station_index, line, total_cost, last, no_stations,
                  overflow, input ready);
  modport sink   (input valid, station_index, line, total_cost, last, no_stations,
                  overflow, output ready);
endinterface

// ===== src/als_cfg_if.sv =====
// register write channel
interface als_cfg_if import als_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== src/assembly_line_schedule.sv =====
// two-line assembly scheduler: add-compare-select per station, traceback on finish
// station words: a new one every cycle while no traceback is emitting, no result
// finish word: first result next cycle, then one per cycle unless out_ch stalls (N for
//   N stored, one if none); predecessor memory is read one station ahead of the output
// reset clears the count, best costs, overflow flag and cost registers; the
//   predecessor memory is not cleared, traceback only reads entries of this problem
module assembly_line_schedule import als_pkg::*; #(
  parameter int MAX_STATIONS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  als_in_if.sink     in_ch,
  als_out_if.source  out_ch,
  als_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_STATIONS + 1);
  localparam int AW = $clog2(MAX_STATIONS);

  als_state_t state_r, state_nxt;

  logic [COST_W-1:0]  entry1_r, entry2_r, exit1_r, exit2_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TOTAL_W-1:0] best1_r, best1_nxt, best2_r, best2_nxt;
  logic               ovf_r, ovf_nxt;

  logic [AW-1:0]      st_r, st_nxt;
  logic               line_r, line_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               nost_r, nost_nxt;
  logic               ovf_out_r, ovf_out_nxt;

  logic [1:0]         pred_mem [MAX_STATIONS];
  logic [1:0]         rd_data_r;
  logic               wr_en;
  logic [1:0]         wr_data;

  logic               in_acc, out_acc, out_last;
  logic [TOTAL_W-1:0] c1, c2, x1, x2;
  logic [TOTAL_W-1:0] stay1, move1, stay2, move2, fin1, fin2;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign out_last = (st_r == '0);

  assign c1 = TOTAL_W'(in_ch.cost_line1);
  assign c2 = TOTAL_W'(in_ch.cost_line2);
  assign x1 = TOTAL_W'(in_ch.xfer_to_line1);
  assign x2 = TOTAL_W'(in_ch.xfer_to_line2);

  assign stay1 = sat_add(best1_r, c1);
  assign move1 = sat_add(sat_add(best2_r, c1), x1);
  assign stay2 = sat_add(best2_r, c2);
  assign move2 = sat_add(sat_add(best1_r, c2), x2);
  assign fin1  = sat_add(best1_r, TOTAL_W'(exit1_r));
  assign fin2  = sat_add(best2_r, TOTAL_W'(exit2_r));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = (state_r == S_EMIT);
  assign out_ch.station_index = STATION_W'(st_r);
  assign out_ch.line          = line_r;
  assign out_ch.total_cost    = total_r;
  assign out_ch.last          = out_last;
  assign out_ch.no_stations   = nost_r;
  assign out_ch.overflow      = ovf_out_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    best1_nxt   = best1_r;
    best2_nxt   = best2_r;
    ovf_nxt     = ovf_r;
    st_nxt      = st_r;
    line_nxt    = line_r;
    total_nxt   = total_r;
    nost_nxt    = nost_r;
    ovf_out_nxt = ovf_out_r;
    wr_en       = 1'b0;
    wr_data     = 2'b00;

    if (in_acc && in_ch.kind == KIND_STATION) begin
      if (count_r >= CW'(MAX_STATIONS)) begin
        ovf_nxt = 1'b1;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        if (count_r == '0) begin
          best1_nxt = sat_add(TOTAL_W'(entry1_r), c1);
          best2_nxt = sat_add(TOTAL_W'(entry2_r), c2);
        end else begin
          // bit 0: line one came from line two; bit 1: line two came from line two
          wr_data[0] = !(stay1 < move1);
          wr_data[1] = (stay2 < move2);
          best1_nxt  = (stay1 < move1) ? stay1 : move1;
          best2_nxt  = (stay2 < move2) ? stay2 : move2;
        end
      end
    end else if (in_acc && in_ch.kind == KIND_FINISH) begin
      state_nxt   = S_EMIT;
      ovf_out_nxt = ovf_r;
      nost_nxt    = (count_r == '0);
      if (count_r == '0) begin
        st_nxt    = '0;
        line_nxt  = 1'b0;
        total_nxt = '0;
      end else begin
        st_nxt    = AW'(count_r - CW'(1));
        line_nxt  = !(fin1 < fin2);
        total_nxt = (fin1 < fin2) ? fin1 : fin2;
      end
      count_nxt = '0;
      best1_nxt = '0;
      best2_nxt = '0;
      ovf_nxt   = 1'b0;
    end

    if (out_acc) begin
      if (out_last) begin
        state_nxt = S_IDLE;
      end else begin
        st_nxt   = st_r - AW'(1);
        line_nxt = rd_data_r[line_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pred_mem[count_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= pred_mem[st_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      best1_r  <= '0;
      best2_r  <= '0;
      ovf_r    <= 1'b0;
      entry1_r <= '0;
      entry2_r <= '0;
      exit1_r  <= '0;
      exit2_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      best1_r <= best1_nxt;
      best2_r <= best2_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.idx))
          CFG_ENTRY_LINE1: entry1_r <= cfg_ch.data;
          CFG_ENTRY_LINE2: entry2_r <= cfg_ch.data;
          CFG_EXIT_LINE1:  exit1_r  <= cfg_ch.data;
          CFG_EXIT_LINE2:  exit2_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r      <= st_nxt;
    line_r    <= line_nxt;
    total_r   <= total_nxt;
    nost_r    <= nost_nxt;
    ovf_out_r <= ovf_out_nxt;
  end

  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken during traceback");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> (in_ch.ready && !out_ch.valid))
    else $error("not idle after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_STATIONS))
    else $error("station count beyond capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_stations) |-> out_ch.last)
    else $error("empty problem result not marked last");

endmodule

// ===== tb/assembly_line_schedule_checker.sv =====
// watches the scheduler channels, predicts every schedule word and compares
`timescale 1ns / 100ps

module assembly_line_schedule_checker import als_pkg::*; #(
  parameter int MAX_STATIONS = 64
) (
  input  logic clk,
  input  logic rst_n,
  als_in_if    in_mon,
  als_out_if   out_mon,
  als_cfg_if   cfg_mon,
  output int   mismatches,
  output int   awaited,
  output int   words_checked,
  output int   problems
);

  localparam logic [TOTAL_W-1:0] COST_CAP = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [STATION_W-1:0] station_index;
    logic                 line;
    logic [TOTAL_W-1:0]   total_cost;
    logic                 last;
    logic                 no_stations;
    logic                 overflow;
  } sched_word_t;

  sched_word_t        sched_q[$];
  logic [TOTAL_W-1:0] entry1, entry2, exit1, exit2;
  logic [TOTAL_W-1:0] run1, run2;
  logic [1:0]         came_from [MAX_STATIONS];
  int                 n_loaded;
  logic               dropped;

  function automatic logic [TOTAL_W-1:0] cost_sum(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] wide;
    wide = a + b;
    return (wide > COST_CAP) ? COST_CAP : wide[TOTAL_W-1:0];
  endfunction

  function automatic void add_station(input logic [COST_W-1:0] c1, c2, x1, x2);
    logic [TOTAL_W-1:0] stay1, move1, stay2, move2;
    if (n_loaded >= MAX_STATIONS) begin
      dropped = 1'b1;
      return;
    end
    if (n_loaded == 0) begin
      run1 = cost_sum(entry1, TOTAL_W'(c1));
      run2 = cost_sum(entry2, TOTAL_W'(c2));
      came_from[0] = 2'b00;
    end else begin
      stay1 = cost_sum(run1, TOTAL_W'(c1));
      move1 = cost_sum(cost_sum(run2, TOTAL_W'(c1)), TOTAL_W'(x1));
      stay2 = cost_sum(run2, TOTAL_W'(c2));
      move2 = cost_sum(cost_sum(run1, TOTAL_W'(c2)), TOTAL_W'(x2));
      // bit 0: line one came from line two, bit 1: line two stayed on line two
      came_from[n_loaded] = {stay2 < move2, !(stay1 < move1)};
      run1 = (stay1 < move1) ? stay1 : move1;
      run2 = (stay2 < move2) ? stay2 : move2;
    end
    n_loaded++;
  endfunction

  function automatic void close_problem();
    logic [TOTAL_W-1:0] fin1, fin2, best;
    logic               on_line;
    sched_word_t        w;
    int                 st;
    w = '0;
    if (n_loaded == 0) begin
      w.last        = 1'b1;
      w.no_stations = 1'b1;
      w.overflow    = dropped;
      sched_q.insert(sched_q.size(), w);
    end else begin
      fin1 = cost_sum(run1, exit1);
      fin2 = cost_sum(run2, exit2);
      if (fin1 < fin2) begin
        best    = fin1;
        on_line = 1'b0;
      end else begin
        best    = fin2;
        on_line = 1'b1;
      end
      for (st = n_loaded - 1; st >= 0; st--) begin
        w.station_index = st[STATION_W-1:0];
        w.line          = on_line;
        w.total_cost    = best;
        w.last          = (st == 0);
        w.no_stations   = 1'b0;
        w.overflow      = dropped;
        sched_q.insert(sched_q.size(), w);
        if (st > 0) on_line = came_from[st][on_line];
      end
    end
    n_loaded = 0;
    run1     = '0;
    run2     = '0;
    dropped  = 1'b0;
    problems++;
  endfunction

  function automatic void note_mismatch(input string what, input sched_word_t want,
                                        input sched_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected st %0d line %0d cost %0d last %0b empty %0b ovf %0b,",
               what, want.station_index, want.line, want.total_cost, want.last,
               want.no_stations, want.overflow);
      $display("  got st %0d line %0d cost %0d last %0b empty %0b ovf %0b",
               got.station_index, got.line, got.total_cost, got.last,
               got.no_stations, got.overflow);
    end
  endfunction

  always @(posedge clk) begin
    sched_word_t got, want;
    if (!rst_n) begin
      entry1        = '0;
      entry2        = '0;
      exit1         = '0;
      exit2         = '0;
      run1          = '0;
      run2          = '0;
      n_loaded      = 0;
      dropped       = 1'b0;
      mismatches    = 0;
      words_checked = 0;
      problems      = 0;
      sched_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.idx)
          CFG_ENTRY_LINE1: entry1 = TOTAL_W'(cfg_mon.data);
          CFG_ENTRY_LINE2: entry2 = TOTAL_W'(cfg_mon.data);
          CFG_EXIT_LINE1:  exit1  = TOTAL_W'(cfg_mon.data);
          CFG_EXIT_LINE2:  exit2  = TOTAL_W'(cfg_mon.data);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_STATION) begin
          add_station(in_mon.cost_line1, in_mon.cost_line2, in_mon.xfer_to_line1,
                      in_mon.xfer_to_line2);
        end else begin
          close_problem();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.station_index = out_mon.station_index;
        got.line          = out_mon.line;
        got.total_cost    = out_mon.total_cost;
        got.last          = out_mon.last;
        got.no_stations   = out_mon.no_stations;
        got.overflow      = out_mon.overflow;
        words_checked++;
        if (sched_q.size() == 0) begin
          note_mismatch("word with nothing expected", '0, got);
        end else begin
          want = sched_q.pop_front();
          if (want.station_index !== got.station_index || want.line !== got.line ||
              want.total_cost !== got.total_cost || want.last !== got.last ||
              want.no_stations !== got.no_stations || want.overflow !== got.overflow) begin
            note_mismatch("schedule word", want, got);
          end
        end
      end
    end
    awaited = sched_q.size();
  end

endmodule

// ===== tb/assembly_line_schedule_test.sv =====
// stimulus, reset, clock and verdict for the assembly line scheduler
`timescale 1ns / 100ps

module assembly_line_schedule_test;
  import als_pkg::*;

  localparam int MAX_STATIONS  = 64;
  localparam int RANDOM_ITEMS  = 440;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst_n;

  als_in_if  in_ch ();
  als_out_if out_ch ();
  als_cfg_if cfg_ch ();

  int          mismatches, awaited, words_checked, problems;
  int          items_sent;
  int          rx_hold;
  int          hold_left;
  bit          idling;
  int unsigned cycle_count;

  assembly_line_schedule #(.MAX_STATIONS(MAX_STATIONS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  assembly_line_schedule_checker #(.MAX_STATIONS(MAX_STATIONS)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .words_checked (words_checked),
    .problems      (problems)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        hold_left = rx_hold - 1;
        rx_hold   = 0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idling && $urandom_range(99) < 14);
      end
    end
  end

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(3))
      0:       return COST_W'($urandom_range(15));
      1:       return COST_W'($urandom_range(255));
      2:       return COST_W'($urandom_range(4095));
      default: return COST_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(255));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 78) return $urandom_range(10, 1);
    if (r < 91) return $urandom_range(MAX_STATIONS - 1, 11);
    if (r < 95) return MAX_STATIONS;
    return $urandom_range(MAX_STATIONS + 6, MAX_STATIONS + 1);
  endfunction

  task automatic send_word(input logic kind, input logic [COST_W-1:0] c1, c2, x1, x2);
    while (idling && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.cost_line1    <= c1;
    in_ch.cost_line2    <= c2;
    in_ch.xfer_to_line1 <= x1;
    in_ch.xfer_to_line2 <= x2;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_finish();
    send_word(KIND_FINISH, pick_cost(), pick_cost(), pick_cost(), pick_cost());
  endtask

  task automatic run_problem(input int stations, input bit tie_style);
    int                k;
    logic [COST_W-1:0] c;
    for (k = 0; k < stations; k++) begin
      if (tie_style) begin
        c = pick_cost();
        send_word(KIND_STATION, c, c, '0, '0);
      end else begin
        send_word(KIND_STATION, pick_cost(), pick_cost(), pick_cost(), pick_cost());
      end
    end
    send_finish();
  endtask

  task automatic await_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= r;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_costs(input logic [CFG_DATA_W-1:0] e1, e2, x1, x2);
    cfg_beat(CFG_ENTRY_LINE1, e1);
    cfg_beat(CFG_ENTRY_LINE2, e2);
    cfg_beat(CFG_EXIT_LINE1, x1);
    cfg_beat(CFG_EXIT_LINE2, x2);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int p;
    int random_start;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_STATION;
    in_ch.cost_line1    <= '0;
    in_ch.cost_line2    <= '0;
    in_ch.xfer_to_line1 <= '0;
    in_ch.xfer_to_line2 <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.idx          <= CFG_ENTRY_LINE1;
    cfg_ch.data         <= '0;
    cycle_count         <= 0;
    items_sent = 0;
    rx_hold    = 0;
    idling     = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty finish, single station
    write_costs(16'd10, 16'd20, 16'd30, 16'd40);
    send_finish();
    send_word(KIND_STATION, 16'd1000, 16'd2000, 16'd5, 16'd5);
    send_finish();
    await_results();

    // ties everywhere
    write_costs(16'd7, 16'd7, 16'd7, 16'd7);
    repeat (3) send_word(KIND_STATION, 16'd100, 16'd100, '0, '0);
    send_finish();
    await_results();

    // largest costs and registers
    write_costs('1, '1, '1, '1);
    repeat (3) send_word(KIND_STATION, '1, '1, '1, '1);
    send_word(KIND_STATION, '0, '0, '0, '0);
    send_finish();
    await_results();

    // transfers that pay off
    write_costs('0, '0, '0, '0);
    send_word(KIND_STATION, 16'd1, 16'd500, '0, '1);
    send_word(KIND_STATION, 16'd500, 16'd1, '0, '0);
    send_word(KIND_STATION, 16'd1, 16'd500, '0, '0);
    send_finish();

    random_start = items_sent;
    p = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (p % 5 == 0) begin
        await_results();
        write_costs(pick_reg(), pick_reg(), pick_reg(), pick_reg());
      end
      if (p == 12) idling = 1'b0;
      if (p == 22) idling = 1'b1;
      if (p == 8) begin
        // hold the result side while an over-capacity problem is traced back and the next waits
        rx_hold = LONG_HOLD;
        run_problem(MAX_STATIONS + 2, 1'b0);
        run_problem(20, 1'b0);
        await_results();
      end else begin
        run_problem(pick_length(), $urandom_range(4) == 0);
        if ($urandom_range(7) == 0) await_results();
      end
      p++;
    end
    await_results();

    $display("drove %0d input words over %0d schedules, checked %0d result words",
             items_sent, problems, words_checked);
    if (mismatches == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== assembly_line_schedule.f =====
src/als_pkg.sv
src/als_in_if.sv
src/als_out_if.sv
src/als_cfg_if.sv
src/assembly_line_schedule.sv
tb/assembly_line_schedule_checker.sv
tb/assembly_line_schedule_test.sv
